// ===== sv/epa_pkg.sv =====
// Shared types and constants for the ephemeral port allocator.
// No dependencies; the front, the back, the top level and the testbench import this package.
package epa_pkg;

  // Operation codes carried in the op field of a request.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_NOT_IN_USE = 2'd2;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  localparam logic [15:0] RANGE_START_RST = 16'd1024;
  localparam logic [16:0] RANGE_END_RST   = 17'd5000;
  localparam logic [7:0]  COUNT_MAX       = 8'd255;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] port;
  } req_t;

  typedef struct packed {
    logic [15:0] port_out;
    logic [1:0]  status;
  } rsp_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic        in_range;
    logic [15:0] offset;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RSP_W = $bits(rsp_t);

endpackage

// ===== sv/epa_fifo.sv =====
// Small synchronous queue used between the front and the back and on the result side.
// Depends on nothing; data is an untyped vector of width W.
module epa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [W-1:0]  data [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/epa_front.sv =====
// Front end: classifies an incoming request against the configured range.
// Depends on epa_pkg for the request and command types.
module epa_front (
  input  epa_pkg::req_t  request,
  input  logic [15:0]    range_start,
  input  logic [16:0]    eff_end,
  output epa_pkg::cmd_t  cmd
);
  import epa_pkg::*;

  logic lo_ok;
  logic hi_ok;

  assign lo_ok = (request.port >= range_start);
  assign hi_ok = ({1'b0, request.port} < eff_end);

  always_comb begin
    cmd.op       = request.op;
    cmd.in_range = lo_ok && hi_ok;
    // Offset of the port inside the range; only meaningful when in range.
    cmd.offset   = request.port - range_start;
  end

endmodule

// ===== sv/epa_back.sv =====
// Back end: use-count memory, next-fit scan, mark/release updates and clearing sweeps.
// Depends on epa_pkg for command, result and code definitions.
module epa_back #(
  parameter int PORT_SLOTS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   range_start,
  input  logic [16:0]   eff_end,
  input  epa_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output epa_pkg::rsp_t rsp,
  input  logic          rsp_full,
  output logic          rsp_push,
  output logic          init_busy
);
  import epa_pkg::*;

  localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(PORT_SLOTS - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_CLEAR,
    S_EMIT
  } state_t;

  state_t        state;
  logic [15:0]   cursor;
  logic [SW-1:0] clr_addr;
  logic [16:0]   iss_port;
  logic [16:0]   iss_cnt;
  logic          rd_valid;
  logic          rd_last;
  logic [16:0]   rd_port;
  logic [1:0]    cur_op;
  logic [SW-1:0] cur_slot;
  rsp_t          rsp_q;

  logic [7:0]    mem [PORT_SLOTS];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [SW-1:0] mem_wa;
  logic [SW-1:0] mem_ra;
  logic [7:0]    mem_wd;

  logic [16:0]   span;
  logic          range_void;
  logic [16:0]   cur_next;
  logic [16:0]   iss_next;
  logic [16:0]   iss_off;
  logic          issue;
  logic          scan_hit;

  // One step forward through the range, back to its start when leaving it.
  // A range whose end lies above 65536 is walked past 65535; only the low
  // 16 bits of such a port reach the cursor and the result.
  function automatic logic [16:0] step_port(logic [16:0] p, logic [15:0] s,
                                            logic [16:0] e);
    logic [16:0] n;
    n = p + 17'd1;
    return ((n >= {1'b0, s}) && (n < e)) ? n : {1'b0, s};
  endfunction

  assign span       = eff_end - {1'b0, range_start};
  assign range_void = (eff_end <= {1'b0, range_start});
  assign cur_next   = step_port({1'b0, cursor}, range_start, eff_end);
  assign iss_next   = step_port(iss_port, range_start, eff_end);
  assign iss_off    = iss_port - {1'b0, range_start};
  assign issue      = (state == S_SCAN) && (iss_cnt < span);
  assign scan_hit   = rd_valid && (mem_q == 8'd0);

  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign rsp_push  = (state == S_EMIT) && !rsp_full;
  assign rsp       = rsp_q;
  assign init_busy = (state == S_INIT);

  // Memory port control.
  always_comb begin
    mem_ra = iss_off[SW-1:0];
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 8'd0;
    case (state)
      S_IDLE: begin
        mem_ra = cmd.offset[SW-1:0];
      end
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RMW: begin
        mem_wa = cur_slot;
        if (cur_op == OP_MARK) begin
          mem_we = (mem_q != COUNT_MAX);
          mem_wd = mem_q + 8'd1;
        end else begin
          mem_we = (mem_q != 8'd0);
          mem_wd = mem_q - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      cursor   <= RANGE_START_RST;
      rd_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (clr_addr == LAST_SLOT) begin
            clr_addr <= '0;
            state    <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          rd_valid <= 1'b0;
          if (!cmd_empty) begin
            cur_op   <= cmd.op;
            cur_slot <= cmd.offset[SW-1:0];
            case (cmd.op)
              OP_ALLOC: begin
                if (range_void) begin
                  rsp_q <= '{port_out: cursor, status: ST_EXHAUSTED};
                  state <= S_EMIT;
                end else begin
                  iss_port <= cur_next;
                  iss_cnt  <= '0;
                  state    <= S_SCAN;
                end
              end
              OP_MARK: begin
                if (cmd.in_range) begin
                  state <= S_RMW;
                end else begin
                  rsp_q <= '{port_out: cursor, status: ST_OK};
                  state <= S_EMIT;
                end
              end
              OP_RELEASE: begin
                if (cmd.in_range) begin
                  state <= S_RMW;
                end else begin
                  rsp_q <= '{port_out: cursor, status: ST_NOT_IN_USE};
                  state <= S_EMIT;
                end
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_valid <= issue && !scan_hit;
          rd_port  <= iss_port;
          rd_last  <= (iss_cnt == span - 17'd1);
          if (issue) begin
            iss_port <= iss_next;
            iss_cnt  <= iss_cnt + 17'd1;
          end
          if (scan_hit) begin
            cursor   <= rd_port[15:0];
            rsp_q    <= '{port_out: rd_port[15:0], status: ST_OK};
            state    <= S_EMIT;
          end else if (rd_valid && rd_last) begin
            cursor   <= rd_port[15:0];
            rsp_q    <= '{port_out: rd_port[15:0], status: ST_EXHAUSTED};
            state    <= S_EMIT;
          end
        end
        S_RMW: begin
          if ((cur_op == OP_RELEASE) && (mem_q == 8'd0)) begin
            rsp_q <= '{port_out: cursor, status: ST_NOT_IN_USE};
          end else begin
            rsp_q <= '{port_out: cursor, status: ST_OK};
          end
          state <= S_EMIT;
        end
        S_CLEAR: begin
          if (clr_addr == LAST_SLOT) begin
            clr_addr <= '0;
            cursor   <= range_start;
            rsp_q    <= '{port_out: range_start, status: ST_OK};
            state    <= S_EMIT;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_EMIT: begin
          if (!rsp_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (iss_cnt <= span))
    else $error("scan issued more reads than the range holds");

  a_read_tag: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(state) == S_SCAN))
    else $error("scan read tagged valid outside a scan");

  a_exhaust_alloc: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && (rsp_q.status == ST_EXHAUSTED)) |-> (cur_op == OP_ALLOC))
    else $error("exhausted status on an item that is not an allocate");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != S_IDLE))
    else $error("command taken without starting its work");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state != S_IDLE) && (state != S_SCAN) && (state != S_EMIT)))
    else $error("use-count memory written outside an update or clear");
`endif

endmodule

// ===== sv/ephemeral_port_allocator.sv =====
// Top level of the next-fit ephemeral port allocator: configuration port,
// front classifier, command queue, back end and result queue.
// Depends on epa_pkg, epa_front, epa_fifo and epa_back.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -----------------------------------
//   request   push / full            request.op, request.port
//   result    pop / empty            result.port_out, result.status
//   config    psel penable pwrite    paddr, pwdata, prdata (pready high)
//
// A mark or release result reaches the result side after the command queue
// and count read, the count write and the hand-over.
// An allocate examines one port after another, since the single read port
// of the use-count memory checks one port each cycle.
// A clear zeroes one memory entry per cycle.
// After reset the same sweep runs with full held high.
// A stalled result side fills the two-item result queue and then holds the
// back end; the front keeps taking items until the command queue is full.
module ephemeral_port_allocator #(
  parameter int PORT_SLOTS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  // request side
  input  logic          push,
  output logic          full,
  input  epa_pkg::req_t request,
  // result side
  output logic          empty,
  input  logic          pop,
  output epa_pkg::rsp_t result,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import epa_pkg::*;

  // Configuration registers.
  logic [15:0] range_start;
  logic [16:0] range_end;

  // Effective end of the range: the configured end, capped by the slot count.
  logic [17:0] slot_limit;
  logic [16:0] eff_end;

  logic        cfg_write;

  cmd_t        cmd_in;
  cmd_t        cmd_out;
  logic        cmd_full;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        cmd_push;

  rsp_t        rsp_back;
  logic        rsp_push;
  logic        rsp_full;
  logic        init_busy;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register index is the word address; the two low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= RANGE_START_RST;
      range_end   <= RANGE_END_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_RANGE_START) begin
        range_start <= pwdata[15:0];
      end else begin
        range_end <= pwdata[16:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_RANGE_END) begin
      prdata = {15'd0, range_end};
    end else begin
      prdata = {16'd0, range_start};
    end
  end

  assign slot_limit = {2'b00, range_start} + 18'(PORT_SLOTS);
  assign eff_end    = ({1'b0, range_end} < slot_limit) ? range_end : slot_limit[16:0];

  // Items are refused while the post-reset sweep of the use counts runs.
  assign full     = cmd_full || init_busy;
  assign cmd_push = push && !full;

  epa_front u_front (
    .request     (request),
    .range_start (range_start),
    .eff_end     (eff_end),
    .cmd         (cmd_in)
  );

  epa_fifo #(
    .W     (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  epa_back #(
    .PORT_SLOTS (PORT_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .range_start (range_start),
    .eff_end     (eff_end),
    .cmd         (cmd_out),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .rsp         (rsp_back),
    .rsp_full    (rsp_full),
    .rsp_push    (rsp_push),
    .init_busy   (init_busy)
  );

  epa_fifo #(
    .W     (RSP_W),
    .DEPTH (2)
  ) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_push),
    .din   (rsp_back),
    .full  (rsp_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the next-fit ephemeral port allocator.
// Depends on epa_pkg and ephemeral_port_allocator; needs no other file.
module testbench;
  import epa_pkg::*;

  localparam int SLOTS = 4096;
  // Percentage of cycles in which either side holds off.
  localparam int IDLE_PCT = 29;
  // Once the last result has been taken the block is idle; a short wait
  // lets any stray result show before the range is changed or the run ends.
  localparam int DRAIN_CYCLES = 16;
  // The longest quiet stretch of a correct run is one clear or one full scan
  // of the range; this leaves a wide margin.
  localparam int STALL_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  req_t        request = '0;
  logic        empty;
  logic        pop = 1'b0;
  rsp_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the allocator: range registers, cursor and use counts.
  logic [15:0] pred_start;
  logic [16:0] pred_end;
  logic [15:0] pred_cursor;
  logic [7:0]  pred_count [SLOTS];

  // Results still owed by the block, oldest first.
  rsp_t pending_rsp [$];
  int   failures = 0;
  int   stall_cycles = 0;
  // While set, neither side inserts idle cycles.
  bit   steady = 1'b0;

  always #4 clk = ~clk;

  ephemeral_port_allocator #(
    .PORT_SLOTS(SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .empty  (empty),
    .pop    (pop),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // ---------------------------------------------------------------------------
  // Port allocation predictor
  // ---------------------------------------------------------------------------

  // The range ends at range_end, but never reaches past the last slot.
  function automatic int range_limit();
    int s;
    int e;
    s = pred_start;
    e = pred_end;
    return (e < s + SLOTS) ? e : s + SLOTS;
  endfunction

  function automatic bit port_in_range(int p, int end_p);
    int s;
    s = pred_start;
    return p >= s && p < end_p;
  endfunction

  // One step forward, back to the first port when stepping off the range.
  function automatic int next_port(int p, int end_p);
    int s;
    s = pred_start;
    return port_in_range(p + 1, end_p) ? p + 1 : s;
  endfunction

  // Applies one item to the shadow state and returns the result it owes.
  function automatic rsp_t predict_port_op(req_t it);
    int   end_p;
    int   s;
    int   span;
    int   p;
    int   pv;
    int   slot;
    rsp_t r;
    end_p = range_limit();
    s = pred_start;
    pv = it.port;
    slot = (pv - s) % SLOTS;
    r.status = ST_OK;
    case (it.op)
      OP_ALLOC: begin
        if (end_p <= s) begin
          // Empty range: nothing to hand out and the cursor stays put.
          r.status = ST_EXHAUSTED;
        end else begin
          // Next fit: look at every port once, starting after the cursor.
          span = end_p - s;
          p = next_port(pred_cursor, end_p);
          r.status = ST_EXHAUSTED;
          for (int i = 0; i < span; i++) begin
            if (pred_count[(p - s) % SLOTS] == 8'd0) begin
              r.status = ST_OK;
              break;
            end
            if (i + 1 < span) p = next_port(p, end_p);
          end
          pred_cursor = p[15:0];
        end
      end
      OP_MARK: begin
        if (port_in_range(pv, end_p) && pred_count[slot] != COUNT_MAX) begin
          pred_count[slot] = pred_count[slot] + 8'd1;
        end
      end
      OP_RELEASE: begin
        if (port_in_range(pv, end_p) && pred_count[slot] != 8'd0) begin
          pred_count[slot] = pred_count[slot] - 8'd1;
        end else begin
          r.status = ST_NOT_IN_USE;
        end
      end
      default: begin
        foreach (pred_count[k]) pred_count[k] = 8'd0;
        pred_cursor = pred_start;
      end
    endcase
    // Every result carries the cursor as it stands after the item.
    r.port_out = pred_cursor;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: takes results with random stalls and compares each one
  // with the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_rsp.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual port_out %0d status %0d",
                   $time, result.port_out, result.status);
        end else begin
          want = pending_rsp.pop_front();
          if (result.port_out !== want.port_out) begin
            failures++;
            $display("%0t: port_out mismatch, expected %0d, actual %0d",
                     $time, want.port_out, result.port_out);
          end
          if (result.status !== want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, result.status);
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offers one item, waits until it is taken and records what it should give.
  // push is left high so that back-to-back items are offered without a gap.
  task automatic send_port_op(input req_t it, output rsp_t want);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    request <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    want = predict_port_op(it);
    pending_rsp.push_back(want);
  endtask

  task automatic run_op(input logic [1:0] op, input logic [15:0] port);
    req_t it;
    rsp_t unused;
    it.op = op;
    it.port = port;
    send_port_op(it, unused);
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write (setup, access) followed by a read-back of the same
  // register. psel stays high between the two transfers.
  task automatic apb_write_reg(input logic reg_idx, input logic [16:0] value);
    logic [16:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {15'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == REG_RANGE_START) pred_start = value[15:0];
    else pred_end = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mask = (reg_idx == REG_RANGE_START) ? 17'h0FFFF : 17'h1FFFF;
    if ((prdata[16:0] & mask) !== (value & mask)) begin
      failures++;
      $display("%0t: register %0d read-back mismatch, expected %0d, actual %0d",
               $time, reg_idx, value & mask, prdata[16:0] & mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reprograms the range once the block has gone quiet.
  task automatic set_range(input logic [15:0] first, input logic [16:0] last);
    wait_idle();
    apb_write_reg(REG_RANGE_START, {1'b0, first});
    apb_write_reg(REG_RANGE_END, last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset range 1024..4999: each operation, field extremes and the ports
  // just inside and just outside both ends of the range.
  task automatic test_basic_ops();
    run_op(OP_ALLOC, 16'h0000);
    run_op(OP_ALLOC, 16'hFFFF);
    run_op(OP_MARK, 16'd1026);
    run_op(OP_MARK, 16'd1024);
    run_op(OP_MARK, 16'd4999);
    run_op(OP_MARK, 16'd5000);
    run_op(OP_MARK, 16'd1023);
    run_op(OP_MARK, 16'h0000);
    run_op(OP_MARK, 16'hFFFF);
    run_op(OP_ALLOC, 16'h1234);
    run_op(OP_RELEASE, 16'hFFFF);
    run_op(OP_RELEASE, 16'h0000);
    run_op(OP_RELEASE, 16'd5000);
    run_op(OP_RELEASE, 16'd1024);
    // A second release of the same port finds its count at zero.
    run_op(OP_RELEASE, 16'd1024);
    run_op(OP_RELEASE, 16'd1026);
    run_op(OP_CLEAR, 16'hA5A5);
    run_op(OP_ALLOC, 16'h5A5A);
  endtask

  // Register extremes, one-port ranges at the top and bottom, empty and
  // inverted ranges, and a cursor left outside a new range.
  task automatic test_range_edges();
    // The end lies far past start plus the slot count, so it is clipped.
    set_range(16'd0, 17'd65536);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_MARK, 16'd4095);
    run_op(OP_MARK, 16'd4096);
    run_op(OP_RELEASE, 16'd4096);
    run_op(OP_RELEASE, 16'd4095);
    set_range(16'd0, 17'd1);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_MARK, 16'd0);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_RELEASE, 16'd0);
    set_range(16'd65535, 17'd65536);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_MARK, 16'd65535);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_RELEASE, 16'd65535);
    run_op(OP_ALLOC, 16'd0);
    // Two ports at the very top: stepping past 65535 wraps to the start.
    set_range(16'd65534, 17'd65536);
    repeat (3) run_op(OP_ALLOC, 16'd0);
    set_range(16'd500, 17'd500);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_MARK, 16'd500);
    run_op(OP_RELEASE, 16'd500);
    // End below start: as empty as the case above.
    set_range(16'd65535, 17'd1);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_MARK, 16'd65535);
    run_op(OP_RELEASE, 16'd0);
    // Fill a four-port range while the cursor is still outside it, then
    // exhaust it from outside and again from inside.
    set_range(16'd300, 17'd304);
    for (int p = 300; p < 304; p++) run_op(OP_MARK, 16'(p));
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_ALLOC, 16'd0);
    run_op(OP_CLEAR, 16'd0);
    run_op(OP_ALLOC, 16'd0);
  endtask

  // Drives one count past its ceiling, then all the way back below zero.
  task automatic test_count_saturation();
    set_range(16'd200, 17'd208);
    repeat (257) run_op(OP_MARK, 16'd203);
    run_op(OP_ALLOC, 16'd0);
    repeat (256) run_op(OP_RELEASE, 16'd203);
  endtask

  // Random traffic in the current range. Most items form allocate-then-mark
  // pairs and releases of ports known to be in use, so small ranges fill up
  // and drain again; the rest is random marks, releases and rare clears.
  task automatic run_workload(input int n_items);
    int          s;
    int          span;
    int          roll;
    int          pick;
    logic [15:0] live [$];
    logic [15:0] follow;
    bit          have_follow;
    req_t        it;
    rsp_t        got;
    s = pred_start;
    span = range_limit() - s;
    have_follow = 1'b0;
    follow = '0;
    for (int k = 0; k < n_items; k++) begin
      it.port = 16'($urandom_range(65535));
      roll = $urandom_range(99);
      if (have_follow && roll < 80) begin
        it.op = OP_MARK;
        it.port = follow;
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) begin
          it.op = OP_ALLOC;
        end else if (roll < 55 && live.size() != 0) begin
          it.op = OP_RELEASE;
          pick = $urandom_range(live.size() - 1);
          it.port = live[pick];
          live.delete(pick);
        end else if (roll < 80 && span > 0) begin
          it.op = (roll < 70) ? OP_MARK : OP_RELEASE;
          it.port = 16'(s + $urandom_range(span - 1));
        end else if (roll < 98) begin
          it.op = (roll % 2 == 0) ? OP_MARK : OP_RELEASE;
        end else begin
          it.op = OP_CLEAR;
          live.delete();
        end
      end
      have_follow = 1'b0;
      send_port_op(it, got);
      if (it.op == OP_MARK && port_in_range(it.port, range_limit())) begin
        live.push_back(it.port);
      end
      if (it.op == OP_ALLOC && got.status == ST_OK) begin
        follow = got.port_out;
        have_follow = 1'b1;
      end
    end
  endtask

  // Eight phases, each in a freshly programmed range: mostly small ranges,
  // some wide ones and one empty one. The fourth is the longest and runs
  // with no idle cycles.
  task automatic test_random_traffic();
    int first;
    int last;
    for (int ph = 0; ph < 8; ph++) begin
      first = $urandom_range(65535);
      case (ph)
        2, 6: last = first + $urandom_range(5000, 1000);
        4: begin
          first = $urandom_range(65535, 1);
          last = $urandom_range(first, 1);
        end
        default: last = first + $urandom_range(48, 1);
      endcase
      if (last > 65536) last = 65536;
      set_range(16'(first), 17'(last));
      steady = (ph == 3);
      run_workload((ph == 3) ? 48 : 16);
      steady = 1'b0;
    end
  endtask

  initial begin
    pred_start = RANGE_START_RST;
    pred_end = RANGE_END_RST;
    pred_cursor = RANGE_START_RST;
    foreach (pred_count[k]) pred_count[k] = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_range_edges();
    test_count_saturation();
    test_random_traffic();
    // Let the last results arrive and give any stray result time to show.
    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
